/* hw/rtl/pdc_pkg.sv */
// pdc_pkg: shared types, codes and the crc-16 byte update for the packet deframer
// no dependencies; compile first

package pdc_pkg;

    // frame markers and widths
    localparam logic [7:0]  SYNC_BYTE   = 8'h42;
    localparam logic [7:0]  BCAST_ADDR  = 8'hff;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam int          MAX_PAYLOAD = 1024;
    localparam int          ELAPSED_W   = 25;
    localparam int          TIMEOUT_W   = 24;
    localparam logic [23:0] TIMEOUT_RST = 24'd20000;
    localparam int          CFG_IDX_W   = 2;
    localparam int          CFG_DATA_W  = 24;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    // frame end status
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_ADDR_BAD = 2'd1;
    localparam logic [1:0] ST_CRC_BAD  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;

    // parser phases, one-hot
    typedef enum logic [7:0] {
        PH_IDLE = 8'b0000_0001,
        PH_ADDR = 8'b0000_0010,
        PH_LEN1 = 8'b0000_0100,
        PH_LEN2 = 8'b0000_1000,
        PH_TYPE = 8'b0001_0000,
        PH_DATA = 8'b0010_0000,
        PH_CRC1 = 8'b0100_0000,
        PH_CRC2 = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_index;
        logic [7:0]  frame_addr;
        logic [7:0]  frame_type;
        logic [15:0] frame_len;
        logic [1:0]  status;
        logic [15:0] computed_crc;
    } out_item_t;

    typedef struct packed {
        logic [7:0]           node_addr;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

    // crc-16 xmodem, one byte msb first, unrolled to xor logic
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/packet_deframer_crc16_check_top.sv */
// packet_deframer_crc16_check_top: serial frame deframer with crc-16 check
// depends on pdc_pkg, pdc_in_stage, pdc_parser
//
// usage
// - input channel (in_valid / in_stall / in_item): one transfer per loop tick,
//   byte_valid marks whether rx_byte carries a received byte
// - output channel (out_valid / out_stall / out_item): payload bytes as they
//   arrive, one status at frame end, one abort when a frame times out
// - config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   the node address, index 1 the timeout in ticks; cfg_ready is always high,
//   write only while no tick is in flight
// - path: a tick transfer is held in the input register, then the parse and
//   crc update load its result into the output register
// - throughput: one tick per cycle while the output is taken; the single-byte
//   crc update and the parse step are combinational
// - reset: parser idle waiting for 0x42, no result held, node address 0,
//   timeout 20000 ticks
// - receiver stall: the result holds in the output register, the next tick
//   waits in the input register, then in_stall rises

module packet_deframer_crc16_check_top
#(
    parameter int MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  pdc_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pdc_pkg::out_item_t                 out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pdc_pkg::cfg_t      cfg_reg;
    pdc_pkg::in_item_t  item;
    logic               item_valid;
    logic               advance;
    logic               res_valid;
    pdc_pkg::out_item_t res;
    logic               out_valid_reg;
    logic               out_valid_next;
    pdc_pkg::out_item_t out_item_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_addr     <= 8'h00;
            cfg_reg.timeout_ticks <= pdc_pkg::TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pdc_pkg::CFG_NODE_ADDR: cfg_reg.node_addr     <= cfg_data[7:0];
                pdc_pkg::CFG_TIMEOUT:   cfg_reg.timeout_ticks <= cfg_data;
                default:                ;
            endcase
        end
    end

    // the held tick moves on when the output register can take a result
    assign advance = item_valid && (!out_valid_reg || !out_stall);

    pdc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pdc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* hw/rtl/pdc_in_stage.sv */
// pdc_in_stage: input register of the deframer, holds one accepted tick
// depends on pdc_pkg

module pdc_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pdc_pkg::in_item_t  in_item,
    input  logic               advance,
    output logic               item_valid,
    output pdc_pkg::in_item_t  item
);

    logic              valid_reg;
    logic              valid_next;
    pdc_pkg::in_item_t item_reg;
    logic              load;

    // hold while the held item cannot move on
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/pdc_parser.sv */
// pdc_parser: frame parser state, crc accumulator, timeout counter and result build
// depends on pdc_pkg

module pdc_parser
#(
    parameter int MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  pdc_pkg::in_item_t  item,
    input  pdc_pkg::cfg_t      cfg,
    output logic               res_valid,
    output pdc_pkg::out_item_t res
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_PAYLOAD);
    localparam logic [pdc_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;

    pdc_pkg::phase_t                phase_reg,   phase_next;
    logic [7:0]                     addr_reg,    addr_next;
    logic [15:0]                    len_reg,     len_next;
    logic [7:0]                     type_reg,    type_next;
    logic [IDX_W-1:0]               index_reg,   index_next;
    logic [15:0]                    crc_reg,     crc_next;
    logic [7:0]                     crc_low_reg, crc_low_next;
    logic [pdc_pkg::ELAPSED_W-1:0]  elapsed_reg, elapsed_next;

    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic [31:0] index_wide;
    logic [16:0] index_inc_ext;
    logic [IDX_W-1:0] index_inc;

    // crc of the current byte over the running value
    assign crc_upd       = pdc_pkg::crc_feed(crc_reg, item.rx_byte);
    assign rx_crc        = {item.rx_byte, crc_low_reg};
    assign index_wide    = 32'(index_reg);
    assign index_inc     = index_reg + 1'b1;
    assign index_inc_ext = 17'(index_inc);

    // next state and result for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        index_next   = index_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        elapsed_next = elapsed_reg;

        res_valid          = 1'b0;
        res                = '0;
        res.frame_addr     = addr_reg;
        res.frame_type     = type_reg;
        res.frame_len      = len_reg;

        // frame timer, checked before the byte
        if (phase_reg != pdc_pkg::PH_IDLE)
        begin
            if (elapsed_reg != ELAPSED_MAX)
            begin
                elapsed_next = elapsed_reg + 1'b1;
            end
            if (elapsed_next > {1'b0, cfg.timeout_ticks})
            begin
                res_valid  = 1'b1;
                res.kind   = pdc_pkg::KIND_ABORT;
                phase_next = pdc_pkg::PH_IDLE;
            end
        end

        // byte parse from the phase left after the timer check
        if (item.byte_valid)
        begin
            case (phase_next)
                pdc_pkg::PH_IDLE:
                begin
                    if (item.rx_byte == pdc_pkg::SYNC_BYTE)
                    begin
                        phase_next   = pdc_pkg::PH_ADDR;
                        addr_next    = '0;
                        len_next     = '0;
                        type_next    = '0;
                        index_next   = '0;
                        crc_low_next = '0;
                        elapsed_next = '0;
                        crc_next     = pdc_pkg::crc_feed(16'h0000, item.rx_byte);
                    end
                end
                pdc_pkg::PH_ADDR:
                begin
                    addr_next  = item.rx_byte;
                    crc_next   = crc_upd;
                    phase_next = pdc_pkg::PH_LEN1;
                end
                pdc_pkg::PH_LEN1:
                begin
                    len_next   = {8'h00, item.rx_byte};
                    crc_next   = crc_upd;
                    phase_next = pdc_pkg::PH_LEN2;
                end
                pdc_pkg::PH_LEN2:
                begin
                    len_next   = {item.rx_byte, len_reg[7:0]};
                    crc_next   = crc_upd;
                    phase_next = pdc_pkg::PH_TYPE;
                end
                pdc_pkg::PH_TYPE:
                begin
                    type_next  = item.rx_byte;
                    crc_next   = crc_upd;
                    index_next = '0;
                    phase_next = (len_reg != 16'h0000) ? pdc_pkg::PH_DATA
                                                       : pdc_pkg::PH_CRC1;
                end
                pdc_pkg::PH_DATA:
                begin
                    // bytes past the buffer are dropped and never finish the frame
                    if (index_reg < IDX_LIMIT)
                    begin
                        res_valid         = 1'b1;
                        res.kind          = pdc_pkg::KIND_PAYLOAD;
                        res.payload_byte  = item.rx_byte;
                        res.payload_index = index_wide[9:0];
                        crc_next          = crc_upd;
                        index_next        = index_inc;
                        if (index_inc_ext >= {1'b0, len_reg})
                        begin
                            phase_next = pdc_pkg::PH_CRC1;
                        end
                    end
                    else if (17'(index_reg) >= {1'b0, len_reg})
                    begin
                        phase_next = pdc_pkg::PH_CRC1;
                    end
                end
                pdc_pkg::PH_CRC1:
                begin
                    crc_low_next = item.rx_byte;
                    phase_next   = pdc_pkg::PH_CRC2;
                end
                pdc_pkg::PH_CRC2:
                begin
                    // address check wins over crc check
                    res_valid        = 1'b1;
                    res.kind         = pdc_pkg::KIND_END;
                    res.computed_crc = crc_reg;
                    if (addr_reg != cfg.node_addr && addr_reg != pdc_pkg::BCAST_ADDR)
                    begin
                        res.status = pdc_pkg::ST_ADDR_BAD;
                    end
                    else if (rx_crc != crc_reg)
                    begin
                        res.status = pdc_pkg::ST_CRC_BAD;
                    end
                    else
                    begin
                        res.status = pdc_pkg::ST_ACCEPTED;
                    end
                    phase_next = pdc_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = pdc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= pdc_pkg::PH_IDLE;
            addr_reg    <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            index_reg   <= '0;
            crc_reg     <= '0;
            crc_low_reg <= '0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            addr_reg    <= addr_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            index_reg   <= index_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

/* bench/pdc_frame_checker.sv */
// pdc_frame_checker: watches the deframer's tick, result and register channels,
// tracks parser state to predict every result and compares each transfer
// depends on pdc_pkg

module pdc_frame_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  pdc_pkg::in_item_t                  in_item,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  pdc_pkg::out_item_t                 out_item,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 errors,
    output int                                 pending,
    output int                                 n_checked,
    output int                                 n_ends,
    output int                                 n_aborts
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [7:0]                    node_c;
    logic [pdc_pkg::TIMEOUT_W-1:0] timeout_c;

    // parser state as seen from outside
    pdc_pkg::phase_t               ph;
    logic [7:0]                    addr_h;
    logic [7:0]                    type_h;
    logic [15:0]                   len_h;
    logic [10:0]                   pos;
    logic [15:0]                   crc_run;
    logic [7:0]                    crc_lo;
    logic [pdc_pkg::ELAPSED_W-1:0] age;

    // results predicted but not yet seen, oldest first
    pdc_pkg::out_item_t due_results[$];

    // crc-16 xmodem, one byte, bit-serial form
    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
            begin
                r = r ^ pdc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // result with the held frame fields filled in
    function automatic pdc_pkg::out_item_t result_of(input logic [1:0] k,
                                                     input logic [7:0] pb,
                                                     input logic [9:0] pi,
                                                     input logic [1:0] st,
                                                     input logic [15:0] crc);
        pdc_pkg::out_item_t r;
        r.kind          = k;
        r.payload_byte  = pb;
        r.payload_index = pi;
        r.frame_addr    = addr_h;
        r.frame_type    = type_h;
        r.frame_len     = len_h;
        r.status        = st;
        r.computed_crc  = crc;
        return r;
    endfunction

    // one tick of the parser: timeout first, then the byte
    task automatic deframe_tick(input logic v, input logic [7:0] b);
        logic [15:0] rx;
        logic [1:0]  st;
        if (ph != pdc_pkg::PH_IDLE)
        begin
            if (age != '1)
            begin
                age = age + 1'b1;
            end
            if (age > {1'b0, timeout_c})
            begin
                due_results.push_back(result_of(pdc_pkg::KIND_ABORT, 8'h00, 10'd0,
                                                pdc_pkg::ST_ACCEPTED, 16'h0));
                ph = pdc_pkg::PH_IDLE;
            end
        end
        if (v)
        begin
            case (ph)
                pdc_pkg::PH_IDLE:
                begin
                    if (b == pdc_pkg::SYNC_BYTE)
                    begin
                        ph      = pdc_pkg::PH_ADDR;
                        addr_h  = 8'h00;
                        len_h   = 16'h0000;
                        type_h  = 8'h00;
                        pos     = '0;
                        crc_lo  = 8'h00;
                        age     = '0;
                        crc_run = crc16_next(16'h0000, b);
                    end
                end
                pdc_pkg::PH_ADDR:
                begin
                    addr_h  = b;
                    crc_run = crc16_next(crc_run, b);
                    ph      = pdc_pkg::PH_LEN1;
                end
                pdc_pkg::PH_LEN1:
                begin
                    len_h   = {8'h00, b};
                    crc_run = crc16_next(crc_run, b);
                    ph      = pdc_pkg::PH_LEN2;
                end
                pdc_pkg::PH_LEN2:
                begin
                    len_h[15:8] = b;
                    crc_run     = crc16_next(crc_run, b);
                    ph          = pdc_pkg::PH_TYPE;
                end
                pdc_pkg::PH_TYPE:
                begin
                    type_h  = b;
                    crc_run = crc16_next(crc_run, b);
                    pos     = '0;
                    if (len_h != 16'h0000)
                    begin
                        ph = pdc_pkg::PH_DATA;
                    end
                    else
                    begin
                        ph = pdc_pkg::PH_CRC1;
                    end
                end
                pdc_pkg::PH_DATA:
                begin
                    // bytes past the payload buffer are dropped
                    if (pos < pdc_pkg::MAX_PAYLOAD)
                    begin
                        due_results.push_back(result_of(pdc_pkg::KIND_PAYLOAD, b, pos[9:0],
                                                        pdc_pkg::ST_ACCEPTED, 16'h0));
                        crc_run = crc16_next(crc_run, b);
                        pos     = pos + 1'b1;
                    end
                    if (16'(pos) >= len_h)
                    begin
                        ph = pdc_pkg::PH_CRC1;
                    end
                end
                pdc_pkg::PH_CRC1:
                begin
                    crc_lo = b;
                    ph     = pdc_pkg::PH_CRC2;
                end
                default:
                begin
                    // address check wins over the crc check
                    rx = {b, crc_lo};
                    if (addr_h != node_c && addr_h != pdc_pkg::BCAST_ADDR)
                    begin
                        st = pdc_pkg::ST_ADDR_BAD;
                    end
                    else if (rx != crc_run)
                    begin
                        st = pdc_pkg::ST_CRC_BAD;
                    end
                    else
                    begin
                        st = pdc_pkg::ST_ACCEPTED;
                    end
                    due_results.push_back(result_of(pdc_pkg::KIND_END, 8'h00, 10'd0, st,
                                                    crc_run));
                    ph = pdc_pkg::PH_IDLE;
                end
            endcase
        end
    endtask

    task automatic field_cmp(input string f, input logic [15:0] want, input logic [15:0] got,
                             inout bit bad);
        if (got !== want)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, f, want, got);
            bad = 1'b1;
        end
    endtask

    // compare one result transfer with the oldest prediction
    task automatic check_result();
        pdc_pkg::out_item_t w;
        bit                 bad;
        bad = 1'b0;
        if (due_results.size() == 0)
        begin
            $display("%0t: result expected none actual %p", $time, out_item);
            errors++;
        end
        else
        begin
            w = due_results.pop_front();
            field_cmp("kind", 16'(w.kind), 16'(out_item.kind), bad);
            field_cmp("payload_byte", 16'(w.payload_byte), 16'(out_item.payload_byte), bad);
            field_cmp("payload_index", 16'(w.payload_index), 16'(out_item.payload_index), bad);
            field_cmp("frame_addr", 16'(w.frame_addr), 16'(out_item.frame_addr), bad);
            field_cmp("frame_type", 16'(w.frame_type), 16'(out_item.frame_type), bad);
            field_cmp("frame_len", w.frame_len, out_item.frame_len, bad);
            field_cmp("status", 16'(w.status), 16'(out_item.status), bad);
            field_cmp("computed_crc", w.computed_crc, out_item.computed_crc, bad);
            if (bad)
            begin
                errors++;
            end
            n_checked++;
            if (w.kind == pdc_pkg::KIND_END)
            begin
                n_ends++;
            end
            if (w.kind == pdc_pkg::KIND_ABORT)
            begin
                n_aborts++;
            end
        end
    endtask

    // sample all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_c    = 8'h00;
            timeout_c = pdc_pkg::TIMEOUT_RST;
            ph        = pdc_pkg::PH_IDLE;
            addr_h    = 8'h00;
            type_h    = 8'h00;
            len_h     = 16'h0000;
            pos       = '0;
            crc_run   = 16'h0000;
            crc_lo    = 8'h00;
            age       = '0;
            due_results.delete();
            errors    = 0;
            n_checked = 0;
            n_ends    = 0;
            n_aborts  = 0;
            pending  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pdc_pkg::CFG_NODE_ADDR: node_c    = cfg_data[7:0];
                    pdc_pkg::CFG_TIMEOUT:   timeout_c = cfg_data[pdc_pkg::TIMEOUT_W-1:0];
                    default:                ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                deframe_tick(in_item.byte_valid, in_item.rx_byte);
            end
            pending <= due_results.size();
        end
    end

endmodule

/* bench/packet_deframer_crc16_check_top_test.sv */
// packet_deframer_crc16_check_top_test: stimulus and verdict for the packet deframer
// depends on pdc_pkg, packet_deframer_crc16_check_top and pdc_frame_checker

module packet_deframer_crc16_check_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TICKS = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLE_PCT     = 10;
    localparam int TO_W         = pdc_pkg::TIMEOUT_W;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    pdc_pkg::in_item_t              in_item   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    pdc_pkg::out_item_t             out_item;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int n_checked;
    int n_ends;
    int n_aborts;

    bit              calm        = 1'b0;
    int              ticks       = 0;
    int              cycles      = 0;
    logic [7:0]      cur_node    = 8'h00;
    logic [TO_W-1:0] cur_timeout = pdc_pkg::TIMEOUT_RST;

    packet_deframer_crc16_check_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pdc_frame_checker deframe_chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .n_checked (n_checked),
        .n_ends    (n_ends),
        .n_aborts  (n_aborts)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 28);
    end

    // one tick transfer, with random idle cycles ahead of it
    task automatic send_tick(input logic v, input logic [7:0] b);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            in_item  <= pdc_pkg::in_item_t'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{byte_valid: v, rx_byte: b};
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        ticks++;
    endtask

    // a received byte, sometimes after an empty tick
    task automatic put_byte(input logic [7:0] b, input int hole_pct);
        if ($urandom_range(99) < hole_pct)
        begin
            send_tick(1'b0, 8'($urandom));
        end
        send_tick(1'b1, b);
    endtask

    // header, nsend payload bytes, and the crc when the frame is complete
    task automatic send_frame(input logic [7:0] addr, input logic [15:0] len,
                              input logic [7:0] ftype, input int nsend,
                              input bit bad_crc, input int hole_pct);
        logic [7:0]  hdr [5];
        logic [15:0] c;
        logic [7:0]  d;
        hdr[0] = pdc_pkg::SYNC_BYTE;
        hdr[1] = addr;
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        hdr[4] = ftype;
        c = 16'h0000;
        for (int k = 0; k < 5; k++)
        begin
            put_byte(hdr[k], hole_pct);
            c = deframe_chk.crc16_next(c, hdr[k]);
        end
        for (int k = 0; k < nsend; k++)
        begin
            d = 8'($urandom);
            put_byte(d, hole_pct);
            if (k < pdc_pkg::MAX_PAYLOAD)
            begin
                c = deframe_chk.crc16_next(c, d);
            end
        end
        if (nsend == int'(len) && int'(len) <= pdc_pkg::MAX_PAYLOAD)
        begin
            if (bad_crc)
            begin
                c = c ^ (16'd1 << $urandom_range(15));
            end
            put_byte(c[7:0], hole_pct);
            put_byte(c[15:8], hole_pct);
        end
    endtask

    // empty ticks until an open frame has timed out
    task automatic wait_abort();
        repeat (int'(cur_timeout) + 2)
        begin
            send_tick(1'b0, 8'($urandom));
        end
    endtask

    // stop sending and let every predicted result come out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pdc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pdc_pkg::CFG_DATA_W-1:0] data);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == pdc_pkg::CFG_NODE_ADDR)
        begin
            cur_node = data[7:0];
        end
        else
        begin
            cur_timeout = data[TO_W-1:0];
        end
    endtask

    task automatic configure(input logic [7:0] node, input logic [TO_W-1:0] to);
        write_reg(pdc_pkg::CFG_NODE_ADDR, {16'($urandom), node});
        write_reg(pdc_pkg::CFG_TIMEOUT, to);
    endtask

    // mostly well-formed frames; noise, cut-off and oversize frames where the
    // timeout is short enough to resync
    task automatic random_frame();
        int          r;
        logic [7:0]  addr;
        logic [15:0] len;
        r = $urandom_range(99);
        case ($urandom_range(3))
            0, 1:    addr = cur_node;
            2:       addr = pdc_pkg::BCAST_ADDR;
            default: addr = 8'($urandom);
        endcase
        if ($urandom_range(9) == 0)
        begin
            len = 16'($urandom_range(13, 40));
        end
        else
        begin
            len = 16'($urandom_range(0, 12));
        end
        if (r < 72 || (r >= 84 && cur_timeout > 300))
        begin
            send_frame(addr, len, 8'($urandom), int'(len), $urandom_range(3) == 0, HOLE_PCT);
        end
        else if (r < 84)
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_tick(1'($urandom), 8'($urandom));
            end
        end
        else if (r < 94)
        begin
            len = 16'($urandom_range(1, 12));
            send_frame(addr, len, 8'($urandom), $urandom_range(0, int'(len) - 1), 1'b0,
                       HOLE_PCT);
            wait_abort();
        end
        else
        begin
            len = 16'($urandom_range(pdc_pkg::MAX_PAYLOAD + 1, 65535));
            send_frame(addr, len, 8'($urandom), $urandom_range(0, 4), 1'b0, HOLE_PCT);
            wait_abort();
        end
    endtask

    initial
    begin
        int              phase;
        int              start;
        logic [7:0]      node;
        logic [TO_W-1:0] to;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle noise: stray bytes and a sync byte without its valid flag
        send_tick(1'b1, 8'h00);
        send_tick(1'b1, 8'hff);
        send_tick(1'b0, pdc_pkg::SYNC_BYTE);
        send_tick(1'b0, 8'h00);

        // reset settings: zero length, broadcast, foreign address, bad crc
        send_frame(8'h00, 16'd0, 8'h00, 0, 1'b0, 0);
        send_frame(pdc_pkg::BCAST_ADDR, 16'd3, 8'hff, 3, 1'b0, 0);
        send_frame(8'h55, 16'd2, 8'h10, 2, 1'b0, 0);
        send_frame(8'h55, 16'd1, 8'h11, 1, 1'b1, 0);
        send_frame(8'h00, 16'd4, 8'h20, 4, 1'b1, 30);

        // short timeout: abort on a sync byte restarts a frame on the same tick
        configure(8'hff, 24'd1);
        send_tick(1'b1, pdc_pkg::SYNC_BYTE);
        send_tick(1'b1, 8'h01);
        send_tick(1'b1, pdc_pkg::SYNC_BYTE);
        send_tick(1'b0, 8'h00);
        send_tick(1'b0, 8'hff);

        // frame declared past the payload buffer: the buffer fills, the rest
        // is dropped, and a few empty ticks run the frame into its timeout
        configure(8'h00, 24'd1040);
        send_frame(8'h00, 16'(pdc_pkg::MAX_PAYLOAD + 6), 8'ha5, pdc_pkg::MAX_PAYLOAD + 6,
                   1'b0, 0);
        repeat (8)
        begin
            send_tick(1'b0, 8'($urandom));
        end
        configure(8'h3c, 24'd20);
        send_frame(8'h3c, 16'hfc05, 8'h77, 3, 1'b0, 0);
        wait_abort();

        // random phases, each under its own register settings
        phase = 0;
        start = ticks;
        while (phase < 4 || ticks - start < RANDOM_TICKS)
        begin
            case (phase % 4)
                0:       to = '1;
                1:       to = TO_W'($urandom_range(40, 200));
                2:       to = pdc_pkg::TIMEOUT_RST;
                default: to = TO_W'($urandom_range(8, 30));
            endcase
            case ($urandom_range(2))
                0:       node = 8'h00;
                1:       node = 8'hff;
                default: node = 8'($urandom);
            endcase
            configure(node, to);
            calm = (phase == 2);
            repeat (8)
            begin
                random_frame();
            end
            phase++;
        end
        calm = 1'b0;
        settle();

        $display("%0d ticks over %0d register settings, %0d results compared",
                 ticks, phase + 4, n_checked);
        $display("%0d frame ends and %0d timeouts among them", n_ends, n_aborts);
        if (errors == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
